FILE: rtl/f32ext_pkg.sv
// ----------------------------------------------------------------------------
// f32ext_pkg
// Shared types, constants and helpers for the float32 extrema block.
// ----------------------------------------------------------------------------
package f32ext_pkg;

    // magnitude mask and sign bit of a float32 word
    localparam logic [31:0] MAG_MASK = 32'h7FFF_FFFF;
    localparam logic [31:0] SIGN_BIT = 32'h8000_0000;
    localparam logic [30:0] MAG_ONES = 31'h7FFF_FFFF;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPECIAL_ENABLE  = 3'd0,
        CFG_SPECIAL_PATTERN = 3'd1,
        CFG_IGNORE_MASK     = 3'd2,
        CFG_PAD_ENABLE      = 3'd3,
        CFG_PAD_VALUE       = 3'd4
    } t_cfg_idx;

    // input request
    typedef struct packed {
        logic [31:0] word;
        logic        last;
    } t_in;

    // result request
    typedef struct packed {
        logic [31:0] max_signed;
        logic [31:0] min_signed;
        logic [30:0] max_abs;
        logic [30:0] min_abs;
        logic [30:0] min_nonzero_abs;
        logic [31:0] special_count;
        logic        all_nonpositive;
        logic        all_nonnegative;
    } t_out;

    // configuration registers
    typedef struct packed {
        logic        special_enable;
        logic [31:0] special_pattern;
        logic [31:0] ignore_mask;
        logic        pad_enable;
        logic [31:0] pad_value;
    } t_cfg;

    // running statistics
    typedef struct packed {
        logic [31:0] max_key;
        logic [31:0] min_key;
        logic [30:0] min_mag;
        logic [30:0] min_nz_mag;
        logic [31:0] tally;
        logic        folded;
    } t_stats;

    localparam t_stats STATS_CLEAR = '{
        max_key:    SIGN_BIT,
        min_key:    MAG_MASK,
        min_mag:    MAG_ONES,
        min_nz_mag: MAG_ONES,
        tally:      32'd0,
        folded:     1'b0
    };

    // order key: signed integer order of keys equals float order
    function automatic logic [31:0] to_key(input logic [31:0] w);
        return w[31] ? (w ^ MAG_MASK) : w;
    endfunction

    function automatic logic key_less(input logic [31:0] a, input logic [31:0] b);
        return $signed(a) < $signed(b);
    endfunction

endpackage

FILE: rtl/f32ext_fold.sv
// ----------------------------------------------------------------------------
// f32ext_fold
// Folds one word into the running statistics and forms the result that a
// closing word would give.
// ----------------------------------------------------------------------------
module f32ext_fold
    import f32ext_pkg::*;
(
    input  t_cfg   i_cfg,
    input  t_stats i_stats,
    input  t_in    i_item,
    output t_stats o_stats,
    output t_out   o_result
);

    logic [31:0] keep;
    logic        special;
    logic        do_fold;
    logic [31:0] fold_word;
    logic [31:0] key;
    logic [30:0] mag;
    logic [31:0] mx;
    logic [31:0] mn;

    // special detection under the ignore mask
    assign keep    = ~i_cfg.ignore_mask;
    assign special = i_cfg.special_enable && (keep != '0) &&
                     ((i_item.word & keep) == (i_cfg.special_pattern & keep));

    // specials are padded, skipped, or kept when the array held nothing else
    assign do_fold   = !special || i_cfg.pad_enable || (i_item.last && !i_stats.folded);
    assign fold_word = (special && i_cfg.pad_enable) ? i_cfg.pad_value : i_item.word;
    assign key       = to_key(fold_word);
    assign mag       = fold_word[30:0];

    // statistics update
    always_comb begin
        o_stats = i_stats;
        if (special && (i_stats.tally != '1)) begin
            o_stats.tally = i_stats.tally + 32'd1;
        end
        if (do_fold) begin
            if (key_less(i_stats.max_key, key)) begin
                o_stats.max_key = key;
            end
            if (key_less(key, i_stats.min_key)) begin
                o_stats.min_key = key;
            end
            if (mag < i_stats.min_mag) begin
                o_stats.min_mag = mag;
            end
            if ((mag != '0) && (mag < i_stats.min_nz_mag)) begin
                o_stats.min_nz_mag = mag;
            end
            o_stats.folded = 1'b1;
        end
    end

    // result from the updated statistics
    assign mx = to_key(o_stats.max_key);
    assign mn = to_key(o_stats.min_key);

    always_comb begin
        o_result.max_signed      = mx;
        o_result.min_signed      = mn;
        o_result.max_abs         = (mx[30:0] > mn[30:0]) ? mx[30:0] : mn[30:0];
        o_result.min_abs         = o_stats.min_mag;
        o_result.min_nonzero_abs = o_stats.min_nz_mag;
        o_result.special_count   = o_stats.tally;
        o_result.all_nonpositive = !key_less(32'd0, o_stats.max_key);
        o_result.all_nonnegative = !key_less(o_stats.min_key, 32'hFFFF_FFFF);
    end

endmodule

FILE: rtl/float32_extrema_with_special.sv
// ----------------------------------------------------------------------------
// float32_extrema_with_special
// Streaming min/max statistics over float32 bit patterns with special-value
// detection, padding and a saturating special count.
// ----------------------------------------------------------------------------
// One word is taken every clock cycle while no stall holds the input. Each
// word is registered, then folded into the running statistics, and the word
// flagged last writes the result register and clears the statistics, so the
// result is offered once the last word leaves the input register. Words keep
// flowing while a result waits; only a further last word stalls until the
// waiting result is taken, the single result register setting that limit.
module float32_extrema_with_special
    import f32ext_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input requests
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in                  i_in,
    // result requests
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out                 o_out,
    // configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    t_cfg   r_cfg;
    t_stats r_stats;
    t_stats n_stats;
    t_in    r_in;
    logic   r_in_valid;
    t_out   r_out;
    t_out   n_out;
    logic   r_out_valid;
    logic   advance;

    // configuration registers, always writable
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_SPECIAL_ENABLE:  r_cfg.special_enable  <= i_cfg_data[0];
                CFG_SPECIAL_PATTERN: r_cfg.special_pattern <= i_cfg_data;
                CFG_IGNORE_MASK:     r_cfg.ignore_mask     <= i_cfg_data;
                CFG_PAD_ENABLE:      r_cfg.pad_enable      <= i_cfg_data[0];
                CFG_PAD_VALUE:       r_cfg.pad_value       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage advances unless a last word meets a full result register
    assign advance    = r_in_valid && (!r_in.last || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in;
        end
    end

    f32ext_fold u_fold (
        .i_cfg    (r_cfg),
        .i_stats  (r_stats),
        .i_item   (r_in),
        .o_stats  (n_stats),
        .o_result (n_out)
    );

    // running statistics, cleared after each closing word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stats <= STATS_CLEAR;
        end else if (advance) begin
            r_stats <= r_in.last ? STATS_CLEAR : n_stats;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in.last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in.last) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef ASSERT_OFF
    // a result only follows a closing word leaving the input register
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(advance && r_in.last))
        else $error("result without a closing word");

    // statistics are clear after a closing word
    a_stats_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in.last) |=> (r_stats.tally == '0 && !r_stats.folded))
        else $error("statistics not cleared after closing word");

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> $stable(r_out))
        else $error("waiting result overwritten");

    // smallest magnitude never exceeds the largest
    a_mag_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.min_abs <= r_out.max_abs))
        else $error("min_abs above max_abs");

    // nonzero minimum is at least the plain minimum
    a_nz_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.min_nonzero_abs >= r_out.min_abs))
        else $error("min_nonzero_abs below min_abs");
`endif

endmodule
